// ===== rtl/core/fwm_pkg.sv =====
package fwm_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE_DIST_CHECK   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE_SOFT_CONTACT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIST_PERIOD         = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONTACT_PERIOD      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_DIST_SQ         = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONTACT_DISCOUNT    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONTACT_GAIN        = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONTACT_LIMIT       = 3'd7;

    localparam logic [23:0] DIST_PERIOD_RST      = 24'd327680;
    localparam logic [23:0] CONTACT_PERIOD_RST   = 24'd6554;
    localparam logic [63:0] MAX_DIST_SQ_RST      = 64'd1073741824;
    localparam logic [15:0] CONTACT_DISCOUNT_RST = 16'd58982;
    localparam logic [15:0] CONTACT_GAIN_RST     = 16'd5958;
    localparam logic [15:0] CONTACT_LIMIT_RST    = 16'd16384;

    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    typedef struct packed {
        logic               command;
        logic [15:0]        elapsed;
        logic signed [31:0] root_x;
        logic signed [31:0] root_y;
        logic signed [31:0] root_z;
        logic               contact;
    } in_item_t;

    typedef struct packed {
        logic        fallen;
        logic        stall_failed;
        logic        contact_failed;
        logic [15:0] contact_level;
    } out_item_t;

endpackage

// ===== rtl/core/fwm_in_if.sv =====
interface fwm_in_if;
    logic             valid;
    logic             ready;
    fwm_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/fwm_out_if.sv =====
interface fwm_out_if;
    logic              valid;
    logic              ready;
    fwm_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/fwm_axis_sq.sv =====
module fwm_axis_sq #(
    parameter int POS_WIDTH = 32
) (
    input  logic [POS_WIDTH-1:0]   pos,
    input  logic [POS_WIDTH-1:0]   last_pos,
    output logic [2*POS_WIDTH-1:0] sq
);

    logic [POS_WIDTH:0]   diff;
    logic [POS_WIDTH:0]   diff_neg;
    logic [POS_WIDTH-1:0] mag;

    always_comb
    begin
        diff     = {pos[POS_WIDTH-1], pos} - {last_pos[POS_WIDTH-1], last_pos};
        diff_neg = (POS_WIDTH+1)'(0) - diff;
        mag      = diff[POS_WIDTH] ? diff_neg[POS_WIDTH-1:0] : diff[POS_WIDTH-1:0];
        sq       = (2*POS_WIDTH)'(mag) * (2*POS_WIDTH)'(mag);
    end

endmodule

// ===== rtl/core/fall_watchdog_monitor.sv =====
// fall watchdog monitor
// ticks channel: one item per simulation tick (command, elapsed, root_x/y/z,
//   contact); command restart reloads both check timers, captures the root
//   position and clears the stall flag and the contact sum
// reports channel: exactly one item per tick item, in order, with fallen,
//   stall_failed, contact_failed and the contact sum after that tick
// config port: cfg_we/cfg_index/cfg_data; the user must write it only while the
//   block is idle (unchecked); new periods take effect at the next timer reload
// pipeline: input register, timer/contact/square stage, sum/compare stage,
//   result register, which drives the reports channel
// throughput: one item per cycle while reports are taken; the contact sum and
//   timer updates feed back into the next item, the three axis multipliers are
//   registered before the saturating sum and limit compare
// a stalled reports channel holds its item; the pipeline keeps filling until
//   every stage is full, then ticks.ready drops
// reset: all config registers take their default values, timers load their
//   periods, positions, stall flag and contact sum clear
module fall_watchdog_monitor #(
    parameter int POS_WIDTH   = 32,
    parameter int TIMER_WIDTH = 25
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [fwm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fwm_pkg::CFG_DATA_W-1:0]  cfg_data,
    fwm_in_if.sink                         ticks,
    fwm_out_if.source                      reports
);

    localparam int CW  = (TIMER_WIDTH > 24) ? TIMER_WIDTH : 24;
    localparam int SQW = 2 * POS_WIDTH;
    localparam logic [TIMER_WIDTH-1:0] TIMER_TOP = {1'b0, {(TIMER_WIDTH-1){1'b1}}};
    localparam logic [TIMER_WIDTH-1:0] DIST_TIMER_RST =
        (CW'(fwm_pkg::DIST_PERIOD_RST) > CW'(TIMER_TOP)) ? TIMER_TOP
                                                         : TIMER_WIDTH'(fwm_pkg::DIST_PERIOD_RST);
    localparam logic [TIMER_WIDTH-1:0] CONTACT_TIMER_RST =
        (CW'(fwm_pkg::CONTACT_PERIOD_RST) > CW'(TIMER_TOP))
            ? TIMER_TOP : TIMER_WIDTH'(fwm_pkg::CONTACT_PERIOD_RST);

    typedef struct packed {
        logic            restart;
        logic            dist_fire;
        logic            contact_failed;
        logic [15:0]     contact_level;
        logic [SQW-1:0]  sq_x;
        logic [SQW-1:0]  sq_y;
        logic [SQW-1:0]  sq_z;
    } mid_t;

    // configuration
    logic        enable_dist_check_reg;
    logic        enable_soft_contact_reg;
    logic [23:0] dist_period_reg;
    logic [23:0] contact_period_reg;
    logic [63:0] max_dist_sq_reg;
    logic [15:0] contact_discount_reg;
    logic [15:0] contact_gain_reg;
    logic [15:0] contact_limit_reg;

    // monitor state
    logic [TIMER_WIDTH-1:0] dist_timer_reg, dist_timer_next;
    logic [TIMER_WIDTH-1:0] contact_timer_reg, contact_timer_next;
    logic [POS_WIDTH-1:0]   last_x_reg, last_y_reg, last_z_reg;
    logic [15:0]            contact_sum_reg, contact_sum_next;
    logic                   stall_flag_reg, stall_flag_next;

    // pipeline
    logic               s0_valid_reg;
    fwm_pkg::in_item_t  s0_item_reg;
    logic               s1_valid_reg;
    mid_t               s1_reg, s1_next;
    logic               out_valid_reg;
    fwm_pkg::out_item_t out_item_reg, out_item_next;

    logic adv0, adv1, take0, take1;

    logic [TIMER_WIDTH-1:0] dist_reload, contact_reload, step_ext;
    logic                   restart, dist_fire, contact_fire, capture;
    logic [31:0]            contact_prod;
    logic [16:0]            contact_raw;
    logic [SQW-1:0]         sq_x, sq_y, sq_z;
    logic [SQW+1:0]         sq_sum;
    logic [63:0]            sq_sat;

    assign adv1        = !out_valid_reg || reports.ready;
    assign adv0        = !s1_valid_reg || adv1;
    assign ticks.ready = !s0_valid_reg || adv0;
    assign take0       = s0_valid_reg && adv0;
    assign take1       = s1_valid_reg && adv1;

    assign reports.valid = out_valid_reg;
    assign reports.data  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_dist_check_reg   <= 1'b1;
            enable_soft_contact_reg <= 1'b1;
            dist_period_reg         <= fwm_pkg::DIST_PERIOD_RST;
            contact_period_reg      <= fwm_pkg::CONTACT_PERIOD_RST;
            max_dist_sq_reg         <= fwm_pkg::MAX_DIST_SQ_RST;
            contact_discount_reg    <= fwm_pkg::CONTACT_DISCOUNT_RST;
            contact_gain_reg        <= fwm_pkg::CONTACT_GAIN_RST;
            contact_limit_reg       <= fwm_pkg::CONTACT_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fwm_pkg::CFG_ENABLE_DIST_CHECK:   enable_dist_check_reg   <= cfg_data[0];
                fwm_pkg::CFG_ENABLE_SOFT_CONTACT: enable_soft_contact_reg <= cfg_data[0];
                fwm_pkg::CFG_DIST_PERIOD:         dist_period_reg         <= cfg_data[23:0];
                fwm_pkg::CFG_CONTACT_PERIOD:      contact_period_reg      <= cfg_data[23:0];
                fwm_pkg::CFG_MAX_DIST_SQ:         max_dist_sq_reg         <= cfg_data[63:0];
                fwm_pkg::CFG_CONTACT_DISCOUNT:    contact_discount_reg    <= cfg_data[15:0];
                fwm_pkg::CFG_CONTACT_GAIN:        contact_gain_reg        <= cfg_data[15:0];
                fwm_pkg::CFG_CONTACT_LIMIT:       contact_limit_reg       <= cfg_data[15:0];
                default:                          ;
            endcase
        end
    end

    // reload values saturate to the timer range
    always_comb
    begin
        dist_reload    = (CW'(dist_period_reg) > CW'(TIMER_TOP))
                         ? TIMER_TOP : TIMER_WIDTH'(dist_period_reg);
        contact_reload = (CW'(contact_period_reg) > CW'(TIMER_TOP))
                         ? TIMER_TOP : TIMER_WIDTH'(contact_period_reg);
    end

    fwm_axis_sq #(.POS_WIDTH(POS_WIDTH)) u_sq_x (
        .pos      (s0_item_reg.root_x[POS_WIDTH-1:0]),
        .last_pos (last_x_reg),
        .sq       (sq_x)
    );

    fwm_axis_sq #(.POS_WIDTH(POS_WIDTH)) u_sq_y (
        .pos      (s0_item_reg.root_y[POS_WIDTH-1:0]),
        .last_pos (last_y_reg),
        .sq       (sq_y)
    );

    fwm_axis_sq #(.POS_WIDTH(POS_WIDTH)) u_sq_z (
        .pos      (s0_item_reg.root_z[POS_WIDTH-1:0]),
        .last_pos (last_z_reg),
        .sq       (sq_z)
    );

    // first stage: timers, contact sum, per-axis squares
    always_comb
    begin
        restart      = (s0_item_reg.command == fwm_pkg::CMD_RESTART);
        step_ext     = TIMER_WIDTH'(s0_item_reg.elapsed);
        dist_fire    = !restart && enable_dist_check_reg && (dist_timer_reg <= step_ext);
        contact_fire = !restart && enable_soft_contact_reg && (contact_timer_reg <= step_ext);
        capture      = restart || dist_fire;

        if (restart || dist_fire)
            dist_timer_next = dist_reload;
        else if (enable_dist_check_reg)
            dist_timer_next = dist_timer_reg - step_ext;
        else
            dist_timer_next = dist_timer_reg;

        if (restart || contact_fire)
            contact_timer_next = contact_reload;
        else if (enable_soft_contact_reg)
            contact_timer_next = contact_timer_reg - step_ext;
        else
            contact_timer_next = contact_timer_reg;

        contact_prod = 32'(contact_discount_reg) * 32'(contact_sum_reg);
        contact_raw  = {1'b0, contact_prod[31:16]}
                     + (s0_item_reg.contact ? {1'b0, contact_gain_reg} : 17'd0);

        if (restart)
            contact_sum_next = 16'd0;
        else if (contact_fire)
            contact_sum_next = contact_raw[16] ? 16'hFFFF : contact_raw[15:0];
        else
            contact_sum_next = contact_sum_reg;

        s1_next.restart        = restart;
        s1_next.dist_fire      = dist_fire;
        s1_next.contact_failed = enable_soft_contact_reg ? (contact_sum_next > contact_limit_reg)
                                                         : s0_item_reg.contact;
        s1_next.contact_level  = contact_sum_next;
        s1_next.sq_x           = sq_x;
        s1_next.sq_y           = sq_y;
        s1_next.sq_z           = sq_z;
    end

    // second stage: saturating sum, limit compare, sticky stall flag
    always_comb
    begin
        sq_sum = (SQW+2)'(s1_reg.sq_x) + (SQW+2)'(s1_reg.sq_y) + (SQW+2)'(s1_reg.sq_z);
        sq_sat = (66'(sq_sum) > 66'(64'hFFFF_FFFF_FFFF_FFFF))
                 ? 64'hFFFF_FFFF_FFFF_FFFF : 64'(sq_sum);

        if (s1_reg.restart)
            stall_flag_next = 1'b0;
        else if (s1_reg.dist_fire && (sq_sat < max_dist_sq_reg))
            stall_flag_next = 1'b1;
        else
            stall_flag_next = stall_flag_reg;

        out_item_next.stall_failed   = stall_flag_next;
        out_item_next.contact_failed = s1_reg.contact_failed;
        out_item_next.fallen         = stall_flag_next | s1_reg.contact_failed;
        out_item_next.contact_level  = s1_reg.contact_level;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_timer_reg    <= DIST_TIMER_RST;
            contact_timer_reg <= CONTACT_TIMER_RST;
            last_x_reg        <= '0;
            last_y_reg        <= '0;
            last_z_reg        <= '0;
            contact_sum_reg   <= '0;
            stall_flag_reg    <= 1'b0;
            s0_valid_reg      <= 1'b0;
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (ticks.ready)
                s0_valid_reg <= ticks.valid;
            if (adv0)
                s1_valid_reg <= s0_valid_reg;
            if (adv1)
                out_valid_reg <= s1_valid_reg;

            if (take0)
            begin
                dist_timer_reg    <= dist_timer_next;
                contact_timer_reg <= contact_timer_next;
                contact_sum_reg   <= contact_sum_next;
                if (capture)
                begin
                    last_x_reg <= s0_item_reg.root_x[POS_WIDTH-1:0];
                    last_y_reg <= s0_item_reg.root_y[POS_WIDTH-1:0];
                    last_z_reg <= s0_item_reg.root_z[POS_WIDTH-1:0];
                end
            end

            if (take1)
                stall_flag_reg <= stall_flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ticks.valid && ticks.ready)
            s0_item_reg <= ticks.data;
        if (adv0)
            s1_reg <= s1_next;
        if (adv1)
            out_item_reg <= out_item_next;
    end

endmodule
